[rtl/dtv_pkg.sv]
// Package with the beat types, status and kind codes, and element check functions.
`default_nettype none

package dtv_pkg;

   localparam int LEN_BYTES   = 4;
   localparam int VALUE_BYTES = 8;

   localparam logic [2:0] ACT_ANY    = 3'd0;
   localparam logic [2:0] ACT_TAG    = 3'd1;
   localparam logic [2:0] ACT_BOOL   = 3'd2;
   localparam logic [2:0] ACT_INT    = 3'd3;
   localparam logic [2:0] ACT_NUMBER = 3'd4;
   localparam logic [2:0] ACT_BITS   = 3'd5;
   localparam logic [2:0] ACT_OCTETS = 3'd6;
   localparam logic [2:0] ACT_OID    = 3'd7;

   localparam logic [3:0] ST_OK        = 4'd0;
   localparam logic [3:0] ST_HIGH_TAG  = 4'd1;
   localparam logic [3:0] ST_BAD_LEN   = 4'd2;
   localparam logic [3:0] ST_TRUNC     = 4'd3;
   localparam logic [3:0] ST_TAG_MISS  = 4'd4;
   localparam logic [3:0] ST_BOOL      = 4'd5;
   localparam logic [3:0] ST_INT       = 4'd6;
   localparam logic [3:0] ST_TOO_WIDE  = 4'd7;
   localparam logic [3:0] ST_BITS      = 4'd8;
   localparam logic [3:0] ST_UNALIGNED = 4'd9;
   localparam logic [3:0] ST_OID       = 4'd10;

   typedef enum logic [1:0] {
      PH_TAG,
      PH_LEN,
      PH_LONG,
      PH_BODY
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_buffer;
      logic [2:0] action;
      logic [7:0] expected_tag;
   } req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [7:0]  element_tag;
      logic [31:0] content_length;
      logic [2:0]  header_length;
      logic [63:0] number_value;
      logic [2:0]  unused_bits;
      logic        bool_value;
   } rsp_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [31:0] content_length;
      logic [63:0] number_value;
      logic [2:0]  unused_bits;
      logic        bool_value;
   } fin_type;

   function automatic logic [7:0] fixed_tag(input logic [2:0] act);
      logic [7:0] t;
      unique case (act)
         ACT_BOOL:              t = 8'd1;
         ACT_INT, ACT_NUMBER:   t = 8'd2;
         ACT_BITS, ACT_OCTETS:  t = 8'd3;
         ACT_OID:               t = 8'd6;
         default:               t = 8'd0;
      endcase
      return t;
   endfunction

   function automatic fin_type finish(
      input logic [2:0]  kind,
      input logic [31:0] dlen,
      input logic [7:0]  first,
      input logic        fault,
      input logic        arc,
      input logic [63:0] accum,
      input logic [7:0]  lastb
   );
      fin_type    f;
      logic [7:0] mask;
      f = '0;
      f.content_length = dlen;
      mask = (8'd1 << first[2:0]) - 8'd1;
      unique case (kind)
         ACT_BOOL: begin
            if (dlen != 32'd1 || fault) begin
               f.status = ST_BOOL;
            end else begin
               f.bool_value = (first != 8'd0);
            end
         end
         ACT_INT, ACT_NUMBER: begin
            if (dlen == 32'd0 || first[7]) begin
               f.status = ST_INT;
            end else if (dlen > 32'd1 && first == 8'd0) begin
               if (fault) begin
                  f.status = ST_INT;
               end else begin
                  f.content_length = dlen - 32'd1;
               end
            end
            if (f.status == ST_OK && kind == ACT_NUMBER) begin
               if (f.content_length > 32'(VALUE_BYTES)) begin
                  f.status = ST_TOO_WIDE;
               end else begin
                  f.number_value = accum;
               end
            end
         end
         ACT_BITS, ACT_OCTETS: begin
            if (dlen == 32'd0 || first > 8'd7) begin
               f.status = ST_BITS;
            end else if (dlen == 32'd1 ? (first != 8'd0) : ((lastb & mask) != 8'd0)) begin
               f.status = ST_BITS;
            end else if (kind == ACT_OCTETS && first != 8'd0) begin
               f.status = ST_UNALIGNED;
            end else begin
               f.unused_bits = first[2:0];
            end
         end
         ACT_OID: begin
            if (dlen == 32'd0 || fault || !arc) begin
               f.status = ST_OID;
            end
         end
         default: begin
            f.status = ST_OK;
         end
      endcase
      if (f.status != ST_OK) begin
         f.content_length = dlen;
      end
      return f;
   endfunction

endpackage

`default_nettype wire

[rtl/dtv_core.sv]
// Element parser: header and content state machine with one result per element.
`default_nettype none

module dtv_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire dtv_pkg::req_type beat,
   output logic                  emit,
   output dtv_pkg::rsp_type      result
);

   dtv_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  tag_ff, tag_in;
   logic [2:0]  kind_ff, kind_in;
   logic [3:0]  lbl_ff, lbl_in;
   logic [2:0]  hcnt_ff, hcnt_in;
   logic [31:0] dlen_ff, dlen_in;
   logic [31:0] cleft_ff, cleft_in;
   logic [7:0]  first_ff, first_in;
   logic [1:0]  cidx_ff, cidx_in;
   logic [63:0] accum_ff, accum_in;
   logic        arc_ff, arc_in;
   logic        drop_ff, drop_in;
   logic        fault_ff, fault_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dtv_pkg::PH_TAG;
         tag_ff   <= '0;
         kind_ff  <= '0;
         lbl_ff   <= '0;
         hcnt_ff  <= '0;
         dlen_ff  <= '0;
         cleft_ff <= '0;
         first_ff <= '0;
         cidx_ff  <= '0;
         accum_ff <= '0;
         arc_ff   <= 1'b1;
         drop_ff  <= 1'b0;
         fault_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         tag_ff   <= tag_in;
         kind_ff  <= kind_in;
         lbl_ff   <= lbl_in;
         hcnt_ff  <= hcnt_in;
         dlen_ff  <= dlen_in;
         cleft_ff <= cleft_in;
         first_ff <= first_in;
         cidx_ff  <= cidx_in;
         accum_ff <= accum_in;
         arc_ff   <= arc_in;
         drop_ff  <= drop_in;
         fault_ff <= fault_in;
      end
   end

   always_comb begin
      logic [7:0]       b;
      logic             last;
      logic [6:0]       w;
      logic [31:0]      ndl;
      logic [31:0]      ncleft;
      logic             use_fin;
      logic [3:0]       st;
      logic [31:0]      clen;
      dtv_pkg::fin_type fin;

      b        = beat.data_byte;
      last     = beat.end_of_buffer;
      w        = b[6:0];
      ndl      = {dlen_ff[23:0], b};
      ncleft   = cleft_ff - 32'd1;
      use_fin  = 1'b0;
      st       = dtv_pkg::ST_OK;
      clen     = '0;
      emit     = 1'b0;
      fin      = '0;

      phase_in = phase_ff;
      tag_in   = tag_ff;
      kind_in  = kind_ff;
      lbl_in   = lbl_ff;
      hcnt_in  = hcnt_ff;
      dlen_in  = dlen_ff;
      cleft_in = cleft_ff;
      first_in = first_ff;
      cidx_in  = cidx_ff;
      accum_in = accum_ff;
      arc_in   = arc_ff;
      drop_in  = drop_ff;
      fault_in = fault_ff;

      if (drop_ff) begin
         if (last) begin
            drop_in = 1'b0;
         end
      end else begin
         unique case (phase_ff)
            dtv_pkg::PH_TAG: begin
               tag_in   = b;
               kind_in  = beat.action;
               hcnt_in  = 3'd1;
               dlen_in  = '0;
               cleft_in = '0;
               lbl_in   = '0;
               first_in = '0;
               cidx_in  = '0;
               accum_in = '0;
               arc_in   = 1'b1;
               fault_in = 1'b0;
               if ((beat.action == dtv_pkg::ACT_TAG && b != beat.expected_tag) ||
                   (beat.action >= dtv_pkg::ACT_BOOL &&
                    b != dtv_pkg::fixed_tag(beat.action))) begin
                  emit = 1'b1;
                  st   = dtv_pkg::ST_TAG_MISS;
               end else if (b[4:0] == 5'h1f) begin
                  emit = 1'b1;
                  st   = dtv_pkg::ST_HIGH_TAG;
               end else if (last) begin
                  emit = 1'b1;
                  st   = dtv_pkg::ST_TRUNC;
               end else begin
                  phase_in = dtv_pkg::PH_LEN;
               end
            end
            dtv_pkg::PH_LEN: begin
               hcnt_in = 3'd2;
               if (b[7]) begin
                  if (w == 7'd0 || w > 7'(dtv_pkg::LEN_BYTES)) begin
                     emit = 1'b1;
                     st   = dtv_pkg::ST_BAD_LEN;
                  end else if (last) begin
                     emit = 1'b1;
                     st   = dtv_pkg::ST_TRUNC;
                  end else begin
                     lbl_in   = w[3:0];
                     phase_in = dtv_pkg::PH_LONG;
                  end
               end else begin
                  dlen_in = {24'd0, b};
                  if (b == 8'd0) begin
                     emit    = 1'b1;
                     use_fin = 1'b1;
                     fin     = dtv_pkg::finish(kind_ff, 32'd0, first_ff, fault_ff, arc_ff,
                                               accum_ff, 8'd0);
                  end else if (last) begin
                     emit = 1'b1;
                     st   = dtv_pkg::ST_TRUNC;
                     clen = {24'd0, b};
                  end else begin
                     cleft_in = {24'd0, b};
                     phase_in = dtv_pkg::PH_BODY;
                  end
               end
            end
            dtv_pkg::PH_LONG: begin
               hcnt_in = hcnt_ff + 3'd1;
               if (hcnt_ff == 3'd2 && b == 8'd0) begin
                  emit = 1'b1;
                  st   = dtv_pkg::ST_BAD_LEN;
               end else if (dlen_ff[31:24] != 8'd0) begin
                  emit = 1'b1;
                  st   = dtv_pkg::ST_BAD_LEN;
               end else begin
                  dlen_in = ndl;
                  lbl_in  = lbl_ff - 4'd1;
                  if (lbl_in != 4'd0) begin
                     if (last) begin
                        emit = 1'b1;
                        st   = dtv_pkg::ST_TRUNC;
                     end
                  end else if (ndl < 32'd128) begin
                     emit = 1'b1;
                     st   = dtv_pkg::ST_BAD_LEN;
                  end else if (last) begin
                     emit = 1'b1;
                     st   = dtv_pkg::ST_TRUNC;
                     clen = ndl;
                  end else begin
                     cleft_in = ndl;
                     phase_in = dtv_pkg::PH_BODY;
                  end
               end
            end
            dtv_pkg::PH_BODY: begin
               if (cidx_ff == 2'd0) begin
                  first_in = b;
               end else if (cidx_ff == 2'd1) begin
                  if ((kind_ff == dtv_pkg::ACT_INT || kind_ff == dtv_pkg::ACT_NUMBER) &&
                      first_ff == 8'd0 && !b[7]) begin
                     fault_in = 1'b1;
                  end
               end
               if (kind_ff == dtv_pkg::ACT_BOOL && b != 8'd0 && b != 8'hff) begin
                  fault_in = 1'b1;
               end
               if (kind_ff == dtv_pkg::ACT_OID) begin
                  if (arc_ff && b == 8'h80) begin
                     fault_in = 1'b1;
                  end
                  arc_in = !b[7];
               end
               accum_in = {accum_ff[55:0], b};
               if (cidx_ff != 2'd2) begin
                  cidx_in = cidx_ff + 2'd1;
               end
               cleft_in = ncleft;
               if (ncleft == 32'd0) begin
                  emit    = 1'b1;
                  use_fin = 1'b1;
                  fin     = dtv_pkg::finish(kind_ff, dlen_ff, first_in, fault_in, arc_in,
                                            accum_in, b);
               end else if (last) begin
                  emit = 1'b1;
                  st   = dtv_pkg::ST_TRUNC;
                  clen = dlen_ff;
               end
            end
            default: begin
               phase_in = dtv_pkg::PH_TAG;
            end
         endcase
      end

      if (!use_fin) begin
         fin.status         = st;
         fin.content_length = clen;
         fin.number_value   = '0;
         fin.unused_bits    = '0;
         fin.bool_value     = 1'b0;
      end
      if (emit) begin
         phase_in = dtv_pkg::PH_TAG;
         drop_in  = (fin.status != dtv_pkg::ST_OK) && !last;
      end

      result.status         = fin.status;
      result.element_tag    = tag_in;
      result.content_length = fin.content_length;
      result.header_length  = hcnt_in;
      result.number_value   = fin.number_value;
      result.unused_bits    = fin.unused_bits;
      result.bool_value     = fin.bool_value;
   end

endmodule

`default_nettype wire

[rtl/der_tlv_stream_validator_top.sv]
// Top level of the DER element validator: input register, parser and result register.
// Bytes pass the input register; a result they end or break is held in the result register.
// One byte per cycle unless stalled; parser state updates once per byte in a single stage.
// A full result register that is not taken stalls the input register and then req_ready.
// Synchronous active-high reset empties both registers and returns the parser to the tag byte.
`default_nettype none

module der_tlv_stream_validator_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire dtv_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output dtv_pkg::rsp_type      rsp_data
);

   logic             in_valid_ff;
   dtv_pkg::req_type in_data_ff;
   logic             rsp_valid_ff;
   dtv_pkg::rsp_type rsp_data_ff;
   logic             out_free;
   logic             step;
   logic             emit;
   dtv_pkg::rsp_type result;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || step;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= step && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         rsp_data_ff <= result;
      end
   end

   dtv_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .beat   (in_data_ff),
      .emit   (emit),
      .result (result)
   );

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |=> in_valid_ff)
      else $error("Held input beat was lost while the result register was full.");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (step && emit) |=> rsp_valid_ff)
      else $error("A parsed element did not reach the result register.");

   a_header_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.header_length != 3'd0 && rsp_data_ff.header_length <= 3'd6))
      else $error("Result header length is out of range.");

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Testbench for the DER element validator: byte streams checked against a local parser.
`timescale 1ns / 1ps

module tb_top;

   typedef enum logic [1:0] {
      SINK_READY,
      SINK_RANDOM,
      SINK_SPARSE
   } sink_mode_type;

   localparam int BEAT_TARGET  = 2000;
   localparam int IDLE_LIMIT   = 5000;
   localparam int DRAIN_CYCLES = 16;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   dtv_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   dtv_pkg::rsp_type rsp_data;

   dtv_pkg::rsp_type pending_reports[$];
   dtv_pkg::rsp_type oldest_report;
   dtv_pkg::req_type buffer_beats[$];
   int               fail_count  = 0;
   int               beats_sent  = 0;
   int               burst_left  = 0;
   int               idle_cycles = 0;
   int               sink_left   = 0;
   sink_mode_type    sink_mode   = SINK_READY;

   dtv_pkg::phase_type der_phase      = dtv_pkg::PH_TAG;
   logic [7:0]         held_tag       = 8'd0;
   logic [2:0]         held_kind      = 3'd0;
   logic [3:0]         len_bytes_left = 4'd0;
   logic [2:0]         hdr_count      = 3'd0;
   logic [31:0]        decl_len       = 32'd0;
   logic [31:0]        body_left      = 32'd0;
   logic [7:0]         first_octet    = 8'd0;
   logic [1:0]         octet_index    = 2'd0;
   logic [63:0]        value_accum    = 64'd0;
   logic               arc_open       = 1'b1;
   logic               skip_to_end    = 1'b0;
   logic               content_bad    = 1'b0;

   der_tlv_stream_validator_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   function automatic logic [7:0] kind_tag(input logic [2:0] kind);
      logic [7:0] t;
      case (kind)
         dtv_pkg::ACT_BOOL:                     t = 8'h01;
         dtv_pkg::ACT_INT, dtv_pkg::ACT_NUMBER:  t = 8'h02;
         dtv_pkg::ACT_BITS, dtv_pkg::ACT_OCTETS: t = 8'h03;
         dtv_pkg::ACT_OID:                      t = 8'h06;
         default:                               t = 8'h00;
      endcase
      return t;
   endfunction

   task automatic post_result(input logic [3:0] st, input logic [31:0] clen,
                              input logic [63:0] val, input logic [2:0] ub,
                              input logic bv, input logic last);
      dtv_pkg::rsp_type r;
      r.status         = st;
      r.element_tag    = held_tag;
      r.content_length = clen;
      r.header_length  = hdr_count;
      r.number_value   = val;
      r.unused_bits    = ub;
      r.bool_value     = bv;
      pending_reports.push_back(r);
      der_phase   = dtv_pkg::PH_TAG;
      skip_to_end = (st != dtv_pkg::ST_OK) && !last;
   endtask

   task automatic close_element(input logic [7:0] lastb, input logic last);
      logic [3:0]  st;
      logic [31:0] clen;
      logic [63:0] val;
      logic [2:0]  ub;
      logic        bv;
      logic [7:0]  mask;
      st   = dtv_pkg::ST_OK;
      clen = decl_len;
      val  = 64'd0;
      ub   = 3'd0;
      bv   = 1'b0;
      mask = (8'd1 << first_octet[2:0]) - 8'd1;
      case (held_kind)
         dtv_pkg::ACT_BOOL: begin
            if (decl_len != 32'd1 || content_bad) st = dtv_pkg::ST_BOOL;
            else bv = (first_octet != 8'd0);
         end
         dtv_pkg::ACT_INT, dtv_pkg::ACT_NUMBER: begin
            if (decl_len == 32'd0 || first_octet[7]) begin
               st = dtv_pkg::ST_INT;
            end else if (decl_len > 32'd1 && first_octet == 8'd0) begin
               if (content_bad) st = dtv_pkg::ST_INT;
               else clen = decl_len - 32'd1;
            end
            if (st == dtv_pkg::ST_OK && held_kind == dtv_pkg::ACT_NUMBER) begin
               if (clen > 32'(dtv_pkg::VALUE_BYTES)) st = dtv_pkg::ST_TOO_WIDE;
               else val = value_accum;
            end
         end
         dtv_pkg::ACT_BITS, dtv_pkg::ACT_OCTETS: begin
            if (decl_len == 32'd0 || first_octet > 8'd7) begin
               st = dtv_pkg::ST_BITS;
            end else if (decl_len == 32'd1 ? (first_octet != 8'd0)
                                           : ((lastb & mask) != 8'd0)) begin
               st = dtv_pkg::ST_BITS;
            end else if (held_kind == dtv_pkg::ACT_OCTETS && first_octet != 8'd0) begin
               st = dtv_pkg::ST_UNALIGNED;
            end else begin
               ub = first_octet[2:0];
            end
         end
         dtv_pkg::ACT_OID: begin
            if (decl_len == 32'd0 || content_bad || !arc_open) st = dtv_pkg::ST_OID;
         end
         default: begin
         end
      endcase
      if (st != dtv_pkg::ST_OK) clen = decl_len;
      post_result(st, clen, val, ub, bv, last);
   endtask

   task automatic parse_der_byte(input dtv_pkg::req_type beat);
      logic [7:0] b;
      logic       last;
      logic [2:0] act;
      logic [6:0] width;
      b     = beat.data_byte;
      last  = beat.end_of_buffer;
      act   = beat.action;
      width = b[6:0];
      if (skip_to_end) begin
         if (last) skip_to_end = 1'b0;
      end else begin
         case (der_phase)
            dtv_pkg::PH_TAG: begin
               held_tag       = b;
               held_kind      = act;
               hdr_count      = 3'd1;
               decl_len       = 32'd0;
               body_left      = 32'd0;
               len_bytes_left = 4'd0;
               first_octet    = 8'd0;
               octet_index    = 2'd0;
               value_accum    = 64'd0;
               arc_open       = 1'b1;
               content_bad    = 1'b0;
               if (act == dtv_pkg::ACT_TAG && b != beat.expected_tag) begin
                  post_result(dtv_pkg::ST_TAG_MISS, 32'd0, 64'd0, 3'd0, 1'b0, last);
               end else if (act >= dtv_pkg::ACT_BOOL && b != kind_tag(act)) begin
                  post_result(dtv_pkg::ST_TAG_MISS, 32'd0, 64'd0, 3'd0, 1'b0, last);
               end else if (b[4:0] == 5'h1F) begin
                  post_result(dtv_pkg::ST_HIGH_TAG, 32'd0, 64'd0, 3'd0, 1'b0, last);
               end else if (last) begin
                  post_result(dtv_pkg::ST_TRUNC, 32'd0, 64'd0, 3'd0, 1'b0, last);
               end else begin
                  der_phase = dtv_pkg::PH_LEN;
               end
            end
            dtv_pkg::PH_LEN: begin
               hdr_count = 3'd2;
               if (b[7]) begin
                  if (width == 7'd0 || width > 7'(dtv_pkg::LEN_BYTES)) begin
                     post_result(dtv_pkg::ST_BAD_LEN, 32'd0, 64'd0, 3'd0, 1'b0, last);
                  end else if (last) begin
                     post_result(dtv_pkg::ST_TRUNC, 32'd0, 64'd0, 3'd0, 1'b0, last);
                  end else begin
                     len_bytes_left = 4'(width);
                     der_phase      = dtv_pkg::PH_LONG;
                  end
               end else begin
                  decl_len = {24'd0, b};
                  if (b == 8'd0) begin
                     close_element(8'd0, last);
                  end else if (last) begin
                     post_result(dtv_pkg::ST_TRUNC, decl_len, 64'd0, 3'd0, 1'b0, last);
                  end else begin
                     body_left = decl_len;
                     der_phase = dtv_pkg::PH_BODY;
                  end
               end
            end
            dtv_pkg::PH_LONG: begin
               hdr_count = hdr_count + 3'd1;
               if (hdr_count == 3'd3 && b == 8'd0) begin
                  post_result(dtv_pkg::ST_BAD_LEN, 32'd0, 64'd0, 3'd0, 1'b0, last);
               end else if (decl_len > 32'h00FF_FFFF) begin
                  post_result(dtv_pkg::ST_BAD_LEN, 32'd0, 64'd0, 3'd0, 1'b0, last);
               end else begin
                  decl_len       = {decl_len[23:0], b};
                  len_bytes_left = len_bytes_left - 4'd1;
                  if (len_bytes_left != 4'd0) begin
                     if (last) begin
                        post_result(dtv_pkg::ST_TRUNC, 32'd0, 64'd0, 3'd0, 1'b0, last);
                     end
                  end else if (decl_len < 32'd128) begin
                     post_result(dtv_pkg::ST_BAD_LEN, 32'd0, 64'd0, 3'd0, 1'b0, last);
                  end else if (last) begin
                     post_result(dtv_pkg::ST_TRUNC, decl_len, 64'd0, 3'd0, 1'b0, last);
                  end else begin
                     body_left = decl_len;
                     der_phase = dtv_pkg::PH_BODY;
                  end
               end
            end
            default: begin
               if (octet_index == 2'd0) begin
                  first_octet = b;
               end else if (octet_index == 2'd1) begin
                  if ((held_kind == dtv_pkg::ACT_INT || held_kind == dtv_pkg::ACT_NUMBER) &&
                      first_octet == 8'd0 && !b[7]) content_bad = 1'b1;
               end
               if (held_kind == dtv_pkg::ACT_BOOL && b != 8'h00 && b != 8'hFF) begin
                  content_bad = 1'b1;
               end
               if (held_kind == dtv_pkg::ACT_OID) begin
                  if (arc_open && b == 8'h80) content_bad = 1'b1;
                  arc_open = !b[7];
               end
               value_accum = {value_accum[55:0], b};
               if (octet_index < 2'd2) octet_index = octet_index + 2'd1;
               body_left = body_left - 32'd1;
               if (body_left == 32'd0) begin
                  close_element(b, last);
               end else if (last) begin
                  post_result(dtv_pkg::ST_TRUNC, decl_len, 64'd0, 3'd0, 1'b0, last);
               end
            end
         endcase
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want_v,
                              input logic [63:0] got_v);
      if (want_v !== got_v) begin
         $error("%s: expected %0h, actual %0h", name, want_v, got_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) parse_der_byte(req_data);
         if (rsp_valid && rsp_ready) begin
            if (pending_reports.size() == 0) begin
               $error("result beat with no element pending, status %0d", rsp_data.status);
               fail_count++;
            end else begin
               oldest_report = pending_reports.pop_front();
               check_field("status", 64'(oldest_report.status), 64'(rsp_data.status));
               check_field("element_tag", 64'(oldest_report.element_tag),
                           64'(rsp_data.element_tag));
               check_field("content_length", 64'(oldest_report.content_length),
                           64'(rsp_data.content_length));
               check_field("header_length", 64'(oldest_report.header_length),
                           64'(rsp_data.header_length));
               check_field("number_value", oldest_report.number_value,
                           rsp_data.number_value);
               check_field("unused_bits", 64'(oldest_report.unused_bits),
                           64'(rsp_data.unused_bits));
               check_field("bool_value", 64'(oldest_report.bool_value),
                           64'(rsp_data.bool_value));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (sink_left == 0) begin
            sink_mode = sink_mode_type'($urandom_range(0, 2));
            sink_left = $urandom_range(8, 120);
         end
         sink_left = sink_left - 1;
         case (sink_mode)
            SINK_READY:  rsp_ready <= 1'b1;
            SINK_RANDOM: rsp_ready <= 1'($urandom_range(0, 1));
            default:     rsp_ready <= ($urandom_range(0, 5) == 0);
         endcase
      end
   end

   task automatic send_beat(input dtv_pkg::req_type beat);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      beats_sent++;
   endtask

   task automatic put_tag(input logic [7:0] b, input logic [2:0] act, input logic [7:0] want);
      dtv_pkg::req_type t;
      t.data_byte     = b;
      t.end_of_buffer = 1'b0;
      t.action        = act;
      t.expected_tag  = want;
      buffer_beats.push_back(t);
   endtask

   task automatic put_byte(input logic [7:0] b);
      put_tag(b, 3'($urandom), 8'($urandom));
   endtask

   task automatic put_length(input int n);
      if (n < 128) begin
         put_byte(8'(n));
      end else if (n < 256) begin
         put_byte(8'h81);
         put_byte(8'(n));
      end else begin
         put_byte(8'h82);
         put_byte(8'(n >> 8));
         put_byte(8'(n));
      end
   endtask

   task automatic send_buffer();
      buffer_beats[buffer_beats.size() - 1].end_of_buffer = 1'b1;
      foreach (buffer_beats[i]) send_beat(buffer_beats[i]);
      buffer_beats.delete();
   endtask

   function automatic int pick_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return $urandom_range(0, 6);
      if (r < 98) return $urandom_range(7, 24);
      return $urandom_range(128, 300);
   endfunction

   task automatic put_random_element(input bit broken);
      logic [2:0] kind;
      logic [2:0] act;
      logic [7:0] tag;
      logic [7:0] want;
      logic [7:0] mask;
      logic [7:0] body[$];
      int         n;
      int         dlen;
      int         unused;
      int         k;
      int         pos;
      bit         lead_zero;
      bit         all_ones;
      kind = 3'($urandom_range(0, 7));
      act  = kind;
      want = 8'($urandom);
      tag  = 8'h00;
      case (kind)
         dtv_pkg::ACT_ANY, dtv_pkg::ACT_TAG: begin
            tag = 8'($urandom);
            if (tag[4:0] == 5'h1F) tag[4] = 1'b0;
            if (kind == dtv_pkg::ACT_TAG && $urandom_range(0, 7) != 0) want = tag;
            n = pick_size();
            repeat (n) body.push_back(8'($urandom));
         end
         dtv_pkg::ACT_BOOL: begin
            tag = 8'h01;
            body.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
         end
         dtv_pkg::ACT_INT, dtv_pkg::ACT_NUMBER: begin
            tag = 8'h02;
            n = (kind == dtv_pkg::ACT_INT) ? pick_size() : $urandom_range(1, 9);
            if (n == 0) n = 1;
            lead_zero = ($urandom_range(0, 3) == 0);
            all_ones  = ($urandom_range(0, 3) == 0);
            if (lead_zero) begin
               body.push_back(8'h00);
               body.push_back(all_ones ? 8'hFF : (8'h80 | 8'($urandom_range(0, 127))));
            end else begin
               body.push_back(8'($urandom_range(1, 127)));
            end
            repeat (n - 1) body.push_back(all_ones ? 8'hFF : 8'($urandom));
         end
         dtv_pkg::ACT_BITS, dtv_pkg::ACT_OCTETS: begin
            tag = 8'h03;
            n = $urandom_range(0, 6);
            unused = (n == 0 || (kind == dtv_pkg::ACT_OCTETS && $urandom_range(0, 3) != 0)) ?
                     0 : $urandom_range(0, 7);
            body.push_back(8'(unused));
            repeat (n) body.push_back(8'($urandom));
            if (n > 0) begin
               mask = (8'd1 << unused) - 8'd1;
               body[body.size() - 1] = body[body.size() - 1] & ~mask;
            end
         end
         default: begin
            tag = 8'h06;
            repeat ($urandom_range(1, 5)) begin
               k = $urandom_range(1, 3);
               if (k > 1) body.push_back(8'h80 | 8'($urandom_range(1, 127)));
               if (k > 2) body.push_back(8'h80 | 8'($urandom));
               body.push_back(8'($urandom_range(0, 127)));
            end
         end
      endcase
      dlen = body.size();
      if (broken) begin
         case ($urandom_range(0, 3))
            0: begin
               if (dlen > 0) begin
                  pos = $urandom_range(0, dlen - 1);
                  body[pos] = body[pos] ^ (8'd1 << $urandom_range(0, 7));
               end
            end
            1: tag = 8'($urandom);
            2: act = 3'($urandom);
            default: dlen = dlen + 1;
         endcase
      end
      put_tag(tag, act, want);
      put_length(dlen);
      foreach (body[i]) put_byte(body[i]);
   endtask

   task automatic put_header_fault();
      logic [7:0] tag;
      int         w;
      tag = 8'($urandom);
      if (tag[4:0] == 5'h1F) tag[4] = 1'b0;
      case ($urandom_range(0, 5))
         0: put_tag(tag | 8'h1F, dtv_pkg::ACT_ANY, 8'($urandom));
         1: begin
            put_tag(tag, dtv_pkg::ACT_ANY, 8'($urandom));
            put_byte(8'h80);
         end
         2: begin
            put_tag(tag, dtv_pkg::ACT_ANY, 8'($urandom));
            put_byte(8'h80 | 8'($urandom_range(dtv_pkg::LEN_BYTES + 1, 127)));
         end
         3: begin
            put_tag(tag, dtv_pkg::ACT_ANY, 8'($urandom));
            put_byte(8'h80 | 8'($urandom_range(1, dtv_pkg::LEN_BYTES)));
            put_byte(8'h00);
         end
         4: begin
            put_tag(tag, dtv_pkg::ACT_ANY, 8'($urandom));
            put_byte(8'h81);
            put_byte(8'($urandom_range(0, 127)));
         end
         default: begin
            w = $urandom_range(3, dtv_pkg::LEN_BYTES);
            put_tag(tag, dtv_pkg::ACT_ANY, 8'($urandom));
            put_byte(8'h80 | 8'(w));
            repeat (w) put_byte(8'($urandom_range(1, 255)));
         end
      endcase
      repeat ($urandom_range(0, 3)) put_byte(8'($urandom));
   endtask

   task automatic test_content_kinds();
      put_tag(8'h01, dtv_pkg::ACT_BOOL, 8'h00);
      put_byte(8'h01);
      put_byte(8'hFF);
      put_tag(8'h02, dtv_pkg::ACT_INT, 8'h00);
      put_byte(8'h02);
      put_byte(8'h00);
      put_byte(8'h80);
      put_tag(8'h02, dtv_pkg::ACT_NUMBER, 8'h00);
      put_byte(8'h01);
      put_byte(8'h7F);
      put_tag(8'h03, dtv_pkg::ACT_BITS, 8'h00);
      put_byte(8'h02);
      put_byte(8'h07);
      put_byte(8'h80);
      put_tag(8'h06, dtv_pkg::ACT_OID, 8'h00);
      put_byte(8'h01);
      put_byte(8'h2A);
      send_buffer();
   endtask

   task automatic test_header_faults();
      // A tag mismatch wins over the high tag form.
      put_tag(8'h1F, dtv_pkg::ACT_TAG, 8'h20);
      send_buffer();
      put_tag(8'h04, dtv_pkg::ACT_ANY, 8'hFF);
      put_byte(8'h80);
      send_buffer();
      // A leading zero length byte is reported even on the last beat.
      put_tag(8'h04, dtv_pkg::ACT_ANY, 8'h00);
      put_byte(8'h82);
      put_byte(8'h00);
      send_buffer();
      put_tag(8'h04, dtv_pkg::ACT_ANY, 8'h00);
      put_byte(8'h81);
      put_byte(8'h7F);
      send_buffer();
      // The beat after the error is dropped along with the end of the buffer.
      put_tag(8'h04, dtv_pkg::ACT_ANY, 8'h00);
      put_byte(8'h85);
      put_byte(8'hAA);
      send_buffer();
   endtask

   task automatic test_truncation();
      put_tag(8'h04, dtv_pkg::ACT_ANY, 8'h00);
      send_buffer();
      put_tag(8'h04, dtv_pkg::ACT_ANY, 8'h00);
      put_byte(8'h82);
      put_byte(8'h01);
      send_buffer();
      put_tag(8'h04, dtv_pkg::ACT_ANY, 8'h00);
      put_byte(8'h03);
      put_byte(8'hAA);
      send_buffer();
   endtask

   task automatic test_random_stream();
      int n_elem;
      int pick;
      int cut;
      while (beats_sent < BEAT_TARGET) begin
         n_elem = $urandom_range(1, 4);
         repeat (n_elem) begin
            pick = $urandom_range(0, 9);
            if (pick < 8) put_random_element(1'b0);
            else if (pick == 8) put_random_element(1'b1);
            else put_header_fault();
         end
         if ($urandom_range(0, 6) == 0) begin
            cut = $urandom_range(1, buffer_beats.size());
            while (buffer_beats.size() > cut) void'(buffer_beats.pop_back());
         end
         send_buffer();
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_content_kinds();
      test_header_faults();
      test_truncation();
      test_random_stream();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
